// File: hw/rtl/swtc_pkg.sv
// ----------------------------------------------------------------------------
// swtc_pkg
// Shared constants, codes and types of the saliency weighted triangle color
// block.
// ----------------------------------------------------------------------------
package swtc_pkg;

   localparam int DEF_POINTS_PER_SIDE = 4;

   localparam int PIX_W      = 8;
   localparam int SAL_W      = 16;
   localparam int WGT_W      = 17;
   localparam int MEAN_W     = 16;
   localparam int QUOT_W     = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TRIS       = 2;
   localparam int CHANS      = 3;
   localparam int LANES      = TRIS * CHANS;

   localparam logic                  USE_SAL_RESET = 1'b1;
   localparam logic [SAL_W-1:0]      BIAS_RESET    = 16'd6554;
   localparam logic [WGT_W-1:0]      WGT_ONE       = 17'h10000;
   localparam logic [MEAN_W-1:0]     MEAN_MAX      = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_ENABLE = 2'd0,
      CSR_WEIGHT_OFFSET = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_RUN  = 3'b010,
      BK_DONE = 3'b100
   } back_state_type;

   // clamp a 17-bit rounded quotient to the 16-bit mean range
   function automatic logic [MEAN_W-1:0] sat_mean(input logic [QUOT_W-1:0] q);
      logic [MEAN_W-1:0] r;
      r = q[QUOT_W-1] ? MEAN_MAX : q[MEAN_W-1:0];
      return r;
   endfunction

endpackage

// File: hw/rtl/swtc_front.sv
// ----------------------------------------------------------------------------
// swtc_front
// Sample accumulator: tracks the grid position, weights each sample and adds
// it into the lower and upper triangle sums; pushes the cell totals on the
// last sample.
// ----------------------------------------------------------------------------
module swtc_front #(
   parameter int POINTS_PER_SIDE = swtc_pkg::DEF_POINTS_PER_SIDE,
   parameter int SUM_W           = 31,
   parameter int WT_W            = 23,
   parameter int SNAP_W          = 6 * SUM_W + 2 * WT_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [swtc_pkg::PIX_W-1:0]      req_pixel_blue,
   input  logic [swtc_pkg::PIX_W-1:0]      req_pixel_green,
   input  logic [swtc_pkg::PIX_W-1:0]      req_pixel_red,
   input  logic [swtc_pkg::SAL_W-1:0]      req_saliency,
   input  logic                            wgt_enable,
   input  logic [swtc_pkg::SAL_W-1:0]      wgt_offset,
   input  swtc_pkg::q_status_type          q_stat,
   output logic                            q_push,
   output logic [SNAP_W-1:0]               q_data
);

   localparam int IW     = $clog2(POINTS_PER_SIDE);
   localparam int PROD_W = swtc_pkg::WGT_W + swtc_pkg::PIX_W;
   localparam logic [IW-1:0] IDX_LAST = IW'(POINTS_PER_SIDE - 1);

   logic [IW-1:0]   i_ff, i_in, j_ff, j_in;
   logic [SUM_W-1:0] sum_ff [swtc_pkg::LANES];
   logic [SUM_W-1:0] sum_in [swtc_pkg::LANES];
   logic [WT_W-1:0]  wsum_ff [swtc_pkg::TRIS];
   logic [WT_W-1:0]  wsum_in [swtc_pkg::TRIS];

   logic                          accept, last, lower, upper;
   logic [IW:0]                   diag;
   logic [swtc_pkg::WGT_W-1:0]    wgt;
   logic [PROD_W-1:0]             prod [swtc_pkg::CHANS];
   logic [swtc_pkg::PIX_W-1:0]    pix  [swtc_pkg::CHANS];
   logic                          tri_sel [swtc_pkg::TRIS];

   assign req_full = q_stat.full;
   assign accept   = req_push & ~req_full;

   assign diag  = {1'b0, i_ff} + {1'b0, j_ff};
   assign lower = diag < (IW + 1)'(POINTS_PER_SIDE);
   assign upper = diag >= (IW + 1)'(POINTS_PER_SIDE - 1);
   assign last  = (i_ff == IDX_LAST) && (j_ff == IDX_LAST);

   assign wgt = wgt_enable ? ({1'b0, req_saliency} + {1'b0, wgt_offset})
                           : swtc_pkg::WGT_ONE;

   assign pix[0] = req_pixel_blue;
   assign pix[1] = req_pixel_green;
   assign pix[2] = req_pixel_red;
   assign tri_sel[0] = lower;
   assign tri_sel[1] = upper;

   always_comb begin
      for (int c = 0; c < swtc_pkg::CHANS; c++) begin
         prod[c] = PROD_W'(wgt) * PROD_W'(pix[c]);
      end
      for (int t = 0; t < swtc_pkg::TRIS; t++) begin
         wsum_in[t] = tri_sel[t] ? wsum_ff[t] + WT_W'(wgt) : wsum_ff[t];
         for (int c = 0; c < swtc_pkg::CHANS; c++) begin
            sum_in[t * swtc_pkg::CHANS + c] = tri_sel[t]
               ? sum_ff[t * swtc_pkg::CHANS + c] + SUM_W'(prod[c])
               : sum_ff[t * swtc_pkg::CHANS + c];
         end
      end
   end

   always_comb begin
      q_data = '0;
      for (int k = 0; k < swtc_pkg::LANES; k++) begin
         q_data[k * SUM_W +: SUM_W] = sum_in[k];
      end
      for (int t = 0; t < swtc_pkg::TRIS; t++) begin
         q_data[swtc_pkg::LANES * SUM_W + t * WT_W +: WT_W] = wsum_in[t];
      end
   end

   assign q_push = accept & last;

   // advance i inside the row, then j
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      if (accept) begin
         if (i_ff == IDX_LAST) begin
            i_in = '0;
            j_in = (j_ff == IDX_LAST) ? '0 : j_ff + 1'b1;
         end else begin
            i_in = i_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         j_ff <= '0;
         for (int k = 0; k < swtc_pkg::LANES; k++) sum_ff[k] <= '0;
         for (int t = 0; t < swtc_pkg::TRIS; t++) wsum_ff[t] <= '0;
      end else begin
         i_ff <= i_in;
         j_ff <= j_in;
         if (accept) begin
            // drop the totals once they are handed to the queue
            for (int k = 0; k < swtc_pkg::LANES; k++) sum_ff[k] <= last ? '0 : sum_in[k];
            for (int t = 0; t < swtc_pkg::TRIS; t++) wsum_ff[t] <= last ? '0 : wsum_in[t];
         end
      end
   end

   a_every_sample_counted: assert property (@(posedge clock) disable iff (reset)
      accept |-> (lower || upper))
      else $error("sample falls in neither triangle");

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (i_ff == '0 && j_ff == '0 && wsum_ff[0] == '0
                            && wsum_ff[1] == '0))
      else $error("cell state not cleared after last sample");

   a_position_in_grid: assert property (@(posedge clock) disable iff (reset)
      (i_ff <= IDX_LAST) && (j_ff <= IDX_LAST))
      else $error("grid position out of range");

endmodule

// File: hw/rtl/swtc_queue.sv
// ----------------------------------------------------------------------------
// swtc_queue
// Two-entry queue of cell totals between the accumulator and the divider.
// ----------------------------------------------------------------------------
module swtc_queue #(
   parameter int DATA_W = 232
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [DATA_W-1:0]      push_data,
   input  logic                   pop,
   output logic [DATA_W-1:0]      head_data,
   output swtc_pkg::q_status_type stat
);

   logic [DATA_W-1:0] ent_ff [2];
   logic              wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign stat.full  = cnt_ff == 2'd2;
   assign stat.empty = cnt_ff == 2'd0;
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign head_data  = ent_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 2'd1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) ent_ff[wr_ff] <= push_data;
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("push into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("pop from an empty queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd3) && ((cnt_ff == 2'd0) == (wr_ff == rd_ff) || cnt_ff == 2'd2))
      else $error("queue count and pointers disagree");

endmodule

// File: hw/rtl/swtc_back.sv
// ----------------------------------------------------------------------------
// swtc_back
// Divider back end: six restoring dividers, one quotient bit per cycle, turn
// the cell totals into rounded Q0.16 means and hold them in the output
// register.
// ----------------------------------------------------------------------------
module swtc_back #(
   parameter int SUM_W  = 31,
   parameter int WT_W   = 23,
   parameter int SNAP_W = 6 * SUM_W + 2 * WT_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swtc_pkg::q_status_type         q_stat,
   input  logic [SNAP_W-1:0]              q_data,
   output logic                           q_pop,
   input  logic                           rsp_pop,
   output logic                           rsp_empty,
   output logic [swtc_pkg::MEAN_W-1:0]    rsp_lower_red,
   output logic [swtc_pkg::MEAN_W-1:0]    rsp_lower_green,
   output logic [swtc_pkg::MEAN_W-1:0]    rsp_lower_blue,
   output logic [swtc_pkg::MEAN_W-1:0]    rsp_upper_red,
   output logic [swtc_pkg::MEAN_W-1:0]    rsp_upper_green,
   output logic [swtc_pkg::MEAN_W-1:0]    rsp_upper_blue,
   output logic                           rsp_weight_zero
);

   localparam int QW     = swtc_pkg::QUOT_W;
   localparam int DEN_W  = WT_W + 8;
   localparam int DVS_W  = DEN_W + 1;
   localparam int REM_W  = DVS_W + 1;
   localparam int NUM_W  = SUM_W + QW + 1;
   localparam int STEP_W = $clog2(QW);
   localparam int NL     = swtc_pkg::LANES;
   localparam int NC     = swtc_pkg::CHANS;
   localparam int NT     = swtc_pkg::TRIS;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QW - 1);

   swtc_pkg::back_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;

   logic [REM_W-1:0]  rem_ff [NL];
   logic [QW-1:0]     quo_ff [NL];
   logic [DVS_W-1:0]  dvs_ff [NT];
   logic              wzero_ff [NT];

   logic [SUM_W-1:0]  sum_hd  [NL];
   logic [WT_W-1:0]   wsum_hd [NT];
   logic [DEN_W-1:0]  den_hd  [NT];
   logic [NUM_W-1:0]  num_hd  [NL];
   logic [REM_W-1:0]  shifted [NL];
   logic [REM_W-1:0]  rem_nx  [NL];
   logic [QW-1:0]     quo_nx  [NL];
   logic [swtc_pkg::MEAN_W-1:0] mean [NL];
   logic              load, out_load;

   logic [swtc_pkg::MEAN_W-1:0] out_mean_ff [NL];
   logic                        out_zero_ff;

   // unpack the cell totals and form divisor and numerator
   always_comb begin
      for (int t = 0; t < NT; t++) begin
         wsum_hd[t] = q_data[NL * SUM_W + t * WT_W +: WT_W];
         den_hd[t]  = {wsum_hd[t], 8'b0} - {8'b0, wsum_hd[t]};
      end
      for (int k = 0; k < NL; k++) begin
         sum_hd[k] = q_data[k * SUM_W +: SUM_W];
         num_hd[k] = {1'b0, sum_hd[k], {QW{1'b0}}}
                   + {{(NUM_W - DEN_W){1'b0}}, den_hd[k / NC]};
      end
   end

   // one restoring step in every lane
   always_comb begin
      for (int k = 0; k < NL; k++) begin
         shifted[k] = {rem_ff[k][REM_W-2:0], quo_ff[k][QW-1]};
         if (shifted[k] >= {1'b0, dvs_ff[k / NC]}) begin
            rem_nx[k] = shifted[k] - {1'b0, dvs_ff[k / NC]};
            quo_nx[k] = {quo_ff[k][QW-2:0], 1'b1};
         end else begin
            rem_nx[k] = shifted[k];
            quo_nx[k] = {quo_ff[k][QW-2:0], 1'b0};
         end
         mean[k] = wzero_ff[k / NC] ? '0 : swtc_pkg::sat_mean(quo_ff[k]);
      end
   end

   assign load     = (state_ff == swtc_pkg::BK_IDLE) && !q_stat.empty;
   assign q_pop    = load;
   assign out_load = (state_ff == swtc_pkg::BK_DONE) && (!out_valid_ff || rsp_pop);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         swtc_pkg::BK_IDLE: begin
            step_in = '0;
            if (load) state_in = swtc_pkg::BK_RUN;
         end
         swtc_pkg::BK_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) state_in = swtc_pkg::BK_DONE;
         end
         swtc_pkg::BK_DONE: begin
            if (out_load) state_in = swtc_pkg::BK_IDLE;
         end
         default: state_in = swtc_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) out_valid_in = 1'b1;
      else if (rsp_pop) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swtc_pkg::BK_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int t = 0; t < NT; t++) begin
            dvs_ff[t]   <= {den_hd[t], 1'b0};
            wzero_ff[t] <= wsum_hd[t] == '0;
         end
         for (int k = 0; k < NL; k++) begin
            rem_ff[k] <= {1'b0, num_hd[k][NUM_W-1:QW]};
            quo_ff[k] <= num_hd[k][QW-1:0];
         end
      end else if (state_ff == swtc_pkg::BK_RUN) begin
         for (int k = 0; k < NL; k++) begin
            rem_ff[k] <= rem_nx[k];
            quo_ff[k] <= quo_nx[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         for (int k = 0; k < NL; k++) out_mean_ff[k] <= mean[k];
         out_zero_ff <= wzero_ff[0] | wzero_ff[1];
      end
   end

   // lanes hold B,G,R per triangle; ports are R,G,B
   assign rsp_empty       = ~out_valid_ff;
   assign rsp_lower_blue  = out_mean_ff[0];
   assign rsp_lower_green = out_mean_ff[1];
   assign rsp_lower_red   = out_mean_ff[2];
   assign rsp_upper_blue  = out_mean_ff[3];
   assign rsp_upper_green = out_mean_ff[4];
   assign rsp_upper_red   = out_mean_ff[5];
   assign rsp_weight_zero = out_zero_ff;

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == swtc_pkg::BK_DONE))
      else $error("result appeared without a finished division");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swtc_pkg::BK_RUN) |-> (step_ff <= STEP_LAST))
      else $error("divider ran past its last step");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff != swtc_pkg::BK_IDLE && dvs_ff[0] != '0)
         |-> (rem_ff[0] < {1'b0, dvs_ff[0]}))
      else $error("partial remainder not below divisor");

endmodule

// File: hw/rtl/saliency_weighted_triangle_color_top.sv
// ----------------------------------------------------------------------------
// saliency_weighted_triangle_color_top
// Weighted mean colors of the two triangles of one grid cell.
// ----------------------------------------------------------------------------
// The block takes POINTS_PER_SIDE squared samples per cell, one per cycle while
// req_full is low, in row order, and after the last one returns both triangle
// means as one result transaction. Samples are accumulated at one per clock
// unless req_full holds them off; each finished cell then goes through a
// two-entry queue into six restoring dividers that make one quotient bit per
// cycle, so a cell passes the back end as one load, 17 steps and one store.
// The accumulator takes the samples of the next cell while the dividers work,
// and one finished cell in the queue, one in the dividers and one result may
// wait without stopping the sample input; a full queue raises req_full.
// Configuration registers are always ready; unknown register indexes are
// ignored.
// ----------------------------------------------------------------------------
module saliency_weighted_triangle_color_top #(
   parameter int POINTS_PER_SIDE = swtc_pkg::DEF_POINTS_PER_SIDE
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [swtc_pkg::PIX_W-1:0]         req_pixel_blue,
   input  logic [swtc_pkg::PIX_W-1:0]         req_pixel_green,
   input  logic [swtc_pkg::PIX_W-1:0]         req_pixel_red,
   input  logic [swtc_pkg::SAL_W-1:0]         req_saliency,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [swtc_pkg::MEAN_W-1:0]        rsp_lower_red,
   output logic [swtc_pkg::MEAN_W-1:0]        rsp_lower_green,
   output logic [swtc_pkg::MEAN_W-1:0]        rsp_lower_blue,
   output logic [swtc_pkg::MEAN_W-1:0]        rsp_upper_red,
   output logic [swtc_pkg::MEAN_W-1:0]        rsp_upper_green,
   output logic [swtc_pkg::MEAN_W-1:0]        rsp_upper_blue,
   output logic                               rsp_weight_zero,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swtc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swtc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CNT_W  = $clog2(POINTS_PER_SIDE * POINTS_PER_SIDE + 1);
   localparam int WT_W   = swtc_pkg::WGT_W + CNT_W;
   localparam int SUM_W  = WT_W + swtc_pkg::PIX_W;
   localparam int SNAP_W = swtc_pkg::LANES * SUM_W + swtc_pkg::TRIS * WT_W;

   logic                         use_sal_ff;
   logic [swtc_pkg::SAL_W-1:0]   bias_ff;
   logic                         csr_wr;

   swtc_pkg::q_status_type       q_stat;
   logic                         q_push, q_pop;
   logic [SNAP_W-1:0]            q_wdata, q_rdata;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_sal_ff <= swtc_pkg::USE_SAL_RESET;
         bias_ff    <= swtc_pkg::BIAS_RESET;
      end else if (csr_wr) begin
         case (swtc_pkg::csr_index_type'(csr_index))
            swtc_pkg::CSR_WEIGHT_ENABLE: use_sal_ff <= csr_data[0];
            swtc_pkg::CSR_WEIGHT_OFFSET: bias_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   swtc_front #(
      .POINTS_PER_SIDE (POINTS_PER_SIDE),
      .SUM_W           (SUM_W),
      .WT_W            (WT_W),
      .SNAP_W          (SNAP_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pixel_blue  (req_pixel_blue),
      .req_pixel_green (req_pixel_green),
      .req_pixel_red   (req_pixel_red),
      .req_saliency    (req_saliency),
      .wgt_enable      (use_sal_ff),
      .wgt_offset      (bias_ff),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_data          (q_wdata)
   );

   swtc_queue #(
      .DATA_W    (SNAP_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .head_data (q_rdata),
      .stat      (q_stat)
   );

   swtc_back #(
      .SUM_W           (SUM_W),
      .WT_W            (WT_W),
      .SNAP_W          (SNAP_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_data          (q_rdata),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_lower_red   (rsp_lower_red),
      .rsp_lower_green (rsp_lower_green),
      .rsp_lower_blue  (rsp_lower_blue),
      .rsp_upper_red   (rsp_upper_red),
      .rsp_upper_green (rsp_upper_green),
      .rsp_upper_blue  (rsp_upper_blue),
      .rsp_weight_zero (rsp_weight_zero)
   );

endmodule
